// ----- hdl/dqpd_pkg.sv -----
// Package for the dual request queue with priority dispatch.
// Descriptor, command and result types, codes and ring index helpers.
// No dependencies.
package dqpd_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int FILL_W      = PTR_W + 1;
   localparam int LIMIT_W     = 6;
   localparam int POL_W       = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 6;
   localparam int CMP_W       = (FILL_W > LIMIT_W) ? FILL_W : LIMIT_W;

   localparam logic [CSR_IDX_W-1:0] CSR_READ_LIMIT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_LIMIT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_READ_POLICY  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_POLICY = 3'd3;

   localparam logic [POL_W-1:0] POL_EVICT_OLDEST = 2'd0;
   localparam logic [POL_W-1:0] POL_EVICT_NEWEST = 2'd1;
   localparam logic [POL_W-1:0] POL_KEEP         = 2'd2;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

   typedef enum logic [1:0] {
      KIND_ENQ_READ  = 2'd0,
      KIND_ENQ_WRITE = 2'd1,
      KIND_TICK      = 2'd2,
      KIND_FINISH    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      EV_DISP_READ  = 2'd0,
      EV_DISP_WRITE = 2'd1,
      EV_EVICT      = 2'd2,
      EV_REJECT     = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      OP_ENQ,
      OP_TICK,
      OP_FINISH
   } op_type;

   typedef struct packed {
      logic [15:0] tag;
      logic [7:0]  slave;
      logic [1:0]  rkind;
      logic [15:0] start;
      logic [10:0] count;
   } desc_type;

   localparam int DESC_W = $bits(desc_type);

   typedef struct packed {
      op_type   op;
      logic     wr_q;
      desc_type desc;
   } cmd_type;

   typedef struct packed {
      event_type ev;
      desc_type  desc;
   } rsp_type;

   typedef struct packed {
      logic                  valid;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_write_type;

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] r;
      if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = ptr + 1'b1;
      end
      return r;
   endfunction

   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0]  ptr,
                                                 input logic [FILL_W-1:0] off);
      logic [FILL_W-1:0] sum;
      sum = FILL_W'(ptr) + off;
      if (sum >= FILL_W'(QUEUE_DEPTH)) begin
         sum = sum - FILL_W'(QUEUE_DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

   // zero counts as one, anything above the ring depth as the depth
   function automatic logic [CMP_W-1:0] eff_limit(input logic [LIMIT_W-1:0] limit);
      logic [CMP_W-1:0] r;
      if (limit == '0) begin
         r = CMP_W'(1);
      end else if (CMP_W'(limit) > CMP_W'(QUEUE_DEPTH)) begin
         r = CMP_W'(QUEUE_DEPTH);
      end else begin
         r = CMP_W'(limit);
      end
      return r;
   endfunction

endpackage

// ----- hdl/dqpd_ram.sv -----
// Generic single write port RAM with registered read.
// No dependencies.
module dqpd_ram #(
   parameter int WIDTH = 53,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = data_ff;

endmodule

// ----- hdl/dqpd_front.sv -----
// Front end: accepts items, classifies them into commands, two entry command queue.
// Uses dqpd_pkg.
module dqpd_front
   import dqpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [1:0] kind,
   input  desc_type   desc,
   output logic       cmd_valid,
   output cmd_type    cmd,
   input  logic       cmd_pop
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    cls;
   logic       do_push, do_pop;

   always_comb begin
      cls.desc = desc;
      cls.wr_q = 1'b0;
      cls.op   = OP_ENQ;
      case (kind_type'(kind))
         KIND_ENQ_READ: begin
            cls.op = OP_ENQ;
         end
         KIND_ENQ_WRITE: begin
            cls.op   = OP_ENQ;
            cls.wr_q = 1'b1;
         end
         KIND_TICK: begin
            cls.op = OP_TICK;
         end
         default: begin
            cls.op = OP_FINISH;
         end
      endcase
   end

   assign full      = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ----- hdl/dqpd_rspq.sv -----
// Two entry result queue between the back end and the result ports.
// Uses dqpd_pkg.
module dqpd_rspq
   import dqpd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  rsp_type wr_data,
   output logic    full,
   output logic    empty,
   output rsp_type rd_data,
   input  logic    rd_en
);

   rsp_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign rd_data = slot_ff[rd_ptr_ff];
   assign do_push = wr_en && !full;
   assign do_pop  = rd_en && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- hdl/dqpd_back.sv -----
// Back end: ring pointers, overflow policy, dispatch and busy flag, config registers.
// Uses dqpd_pkg and two dqpd_ram rings.
module dqpd_back
   import dqpd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  csr_write_type csr,
   input  logic          cmd_valid,
   input  cmd_type       cmd,
   output logic          cmd_pop,
   input  logic          rsp_full,
   output logic          rsp_push,
   output rsp_type       rsp_data
);

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   state_type          state_ff, state_in;
   logic [PTR_W-1:0]   rd_head_ff, rd_head_in;
   logic [FILL_W-1:0]  rd_fill_ff, rd_fill_in;
   logic [PTR_W-1:0]   wr_head_ff, wr_head_in;
   logic [FILL_W-1:0]  wr_fill_ff, wr_fill_in;
   logic               busy_ff, busy_in;
   logic [LIMIT_W-1:0] rd_limit_ff, rd_limit_in;
   logic [LIMIT_W-1:0] wr_limit_ff, wr_limit_in;
   logic [POL_W-1:0]   rd_pol_ff, rd_pol_in;
   logic [POL_W-1:0]   wr_pol_ff, wr_pol_in;

   event_type          pend_ev_ff, pend_ev_in;
   logic               pend_wr_ff, pend_wr_in;
   logic               pend_sel_ff, pend_sel_in;
   logic [PTR_W-1:0]   pend_addr_ff, pend_addr_in;
   desc_type           pend_desc_ff, pend_desc_in;

   logic               ram_re_r, ram_re_w, ram_we_r, ram_we_w;
   logic [PTR_W-1:0]   ram_raddr, ram_waddr;
   logic [DESC_W-1:0]  ram_wdata, rdata_r, rdata_w;

   logic [PTR_W-1:0]   sel_head;
   logic [FILL_W-1:0]  sel_fill;
   logic [CMP_W-1:0]   sel_lim;
   logic [POL_W-1:0]   sel_pol;

   dqpd_ram #(.WIDTH(DESC_W), .DEPTH(QUEUE_DEPTH)) u_read_ring (
      .clock   (clock),
      .wr_en   (ram_we_r),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re_r),
      .rd_addr (ram_raddr),
      .rd_data (rdata_r)
   );

   dqpd_ram #(.WIDTH(DESC_W), .DEPTH(QUEUE_DEPTH)) u_write_ring (
      .clock   (clock),
      .wr_en   (ram_we_w),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re_w),
      .rd_addr (ram_raddr),
      .rd_data (rdata_w)
   );

   assign sel_head = cmd.wr_q ? wr_head_ff : rd_head_ff;
   assign sel_fill = cmd.wr_q ? wr_fill_ff : rd_fill_ff;
   assign sel_lim  = eff_limit(cmd.wr_q ? wr_limit_ff : rd_limit_ff);
   assign sel_pol  = cmd.wr_q ? wr_pol_ff : rd_pol_ff;

   always_comb begin
      logic [PTR_W-1:0]  nh;
      logic [FILL_W-1:0] nf;
      nh           = sel_head;
      nf           = sel_fill;
      state_in     = state_ff;
      rd_head_in   = rd_head_ff;
      rd_fill_in   = rd_fill_ff;
      wr_head_in   = wr_head_ff;
      wr_fill_in   = wr_fill_ff;
      busy_in      = busy_ff;
      rd_limit_in  = rd_limit_ff;
      wr_limit_in  = wr_limit_ff;
      rd_pol_in    = rd_pol_ff;
      wr_pol_in    = wr_pol_ff;
      pend_ev_in   = pend_ev_ff;
      pend_wr_in   = pend_wr_ff;
      pend_sel_in  = pend_sel_ff;
      pend_addr_in = pend_addr_ff;
      pend_desc_in = pend_desc_ff;
      cmd_pop      = 1'b0;
      rsp_push     = 1'b0;
      rsp_data.ev   = pend_ev_ff;
      rsp_data.desc = desc_type'(pend_sel_ff ? rdata_w : rdata_r);
      ram_re_r     = 1'b0;
      ram_re_w     = 1'b0;
      ram_we_r     = 1'b0;
      ram_we_w     = 1'b0;
      ram_raddr    = sel_head;
      ram_waddr    = pend_addr_ff;
      ram_wdata    = DESC_W'(pend_desc_ff);

      if (csr.valid) begin
         case (csr.index)
            CSR_READ_LIMIT:   rd_limit_in = csr.data;
            CSR_WRITE_LIMIT:  wr_limit_in = csr.data;
            CSR_READ_POLICY:  rd_pol_in   = csr.data[POL_W-1:0];
            CSR_WRITE_POLICY: wr_pol_in   = csr.data[POL_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && !rsp_full) begin
               cmd_pop = 1'b1;
               case (cmd.op)
                  OP_FINISH: begin
                     busy_in = 1'b0;
                  end
                  OP_TICK: begin
                     if (!busy_ff && wr_fill_ff != '0) begin
                        ram_raddr   = wr_head_ff;
                        ram_re_w    = 1'b1;
                        pend_sel_in = 1'b1;
                        pend_ev_in  = EV_DISP_WRITE;
                        pend_wr_in  = 1'b0;
                        wr_head_in  = wrap_inc(wr_head_ff);
                        wr_fill_in  = wr_fill_ff - 1'b1;
                        busy_in     = 1'b1;
                        state_in    = ST_READ;
                     end else if (!busy_ff && rd_fill_ff != '0) begin
                        ram_raddr   = rd_head_ff;
                        ram_re_r    = 1'b1;
                        pend_sel_in = 1'b0;
                        pend_ev_in  = EV_DISP_READ;
                        pend_wr_in  = 1'b0;
                        rd_head_in  = wrap_inc(rd_head_ff);
                        rd_fill_in  = rd_fill_ff - 1'b1;
                        busy_in     = 1'b1;
                        state_in    = ST_READ;
                     end
                  end
                  default: begin
                     pend_sel_in  = cmd.wr_q;
                     pend_ev_in   = EV_EVICT;
                     pend_wr_in   = 1'b1;
                     pend_desc_in = cmd.desc;
                     ram_waddr    = wrap_add(sel_head, sel_fill);
                     ram_wdata    = DESC_W'(cmd.desc);
                     if (CMP_W'(sel_fill) >= sel_lim) begin
                        case (sel_pol)
                           POL_EVICT_OLDEST: begin
                              ram_raddr    = sel_head;
                              ram_re_r     = !cmd.wr_q;
                              ram_re_w     = cmd.wr_q;
                              pend_addr_in = wrap_add(sel_head, sel_fill);
                              nh           = wrap_inc(sel_head);
                              state_in     = ST_READ;
                           end
                           POL_EVICT_NEWEST: begin
                              ram_raddr    = wrap_add(sel_head, sel_fill - 1'b1);
                              ram_re_r     = !cmd.wr_q;
                              ram_re_w     = cmd.wr_q;
                              pend_addr_in = wrap_add(sel_head, sel_fill - 1'b1);
                              state_in     = ST_READ;
                           end
                           default: begin
                              if (sel_fill >= FILL_W'(QUEUE_DEPTH)) begin
                                 rsp_push      = 1'b1;
                                 rsp_data.ev   = EV_REJECT;
                                 rsp_data.desc = cmd.desc;
                              end else begin
                                 ram_we_r = !cmd.wr_q;
                                 ram_we_w = cmd.wr_q;
                                 nf       = sel_fill + 1'b1;
                              end
                           end
                        endcase
                     end else begin
                        ram_we_r = !cmd.wr_q;
                        ram_we_w = cmd.wr_q;
                        nf       = sel_fill + 1'b1;
                     end
                     if (cmd.wr_q) begin
                        wr_head_in = nh;
                        wr_fill_in = nf;
                     end else begin
                        rd_head_in = nh;
                        rd_fill_in = nf;
                     end
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_push = 1'b1;
            ram_we_r = pend_wr_ff && !pend_sel_ff;
            ram_we_w = pend_wr_ff && pend_sel_ff;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         rd_head_ff  <= '0;
         rd_fill_ff  <= '0;
         wr_head_ff  <= '0;
         wr_fill_ff  <= '0;
         busy_ff     <= 1'b0;
         rd_limit_ff <= LIMIT_RESET;
         wr_limit_ff <= LIMIT_RESET;
         rd_pol_ff   <= POL_EVICT_OLDEST;
         wr_pol_ff   <= POL_EVICT_OLDEST;
         pend_wr_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_head_ff  <= rd_head_in;
         rd_fill_ff  <= rd_fill_in;
         wr_head_ff  <= wr_head_in;
         wr_fill_ff  <= wr_fill_in;
         busy_ff     <= busy_in;
         rd_limit_ff <= rd_limit_in;
         wr_limit_ff <= wr_limit_in;
         rd_pol_ff   <= rd_pol_in;
         wr_pol_ff   <= wr_pol_in;
         pend_wr_ff  <= pend_wr_in;
      end
      pend_ev_ff   <= pend_ev_in;
      pend_sel_ff  <= pend_sel_in;
      pend_addr_ff <= pend_addr_in;
      pend_desc_ff <= pend_desc_in;
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rd_fill_ff <= FILL_W'(QUEUE_DEPTH) && wr_fill_ff <= FILL_W'(QUEUE_DEPTH))
      else $error("ring fill beyond depth");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed into a full queue");

   a_read_once: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> state_ff == ST_IDLE)
      else $error("ring read state held");

   a_busy_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(busy_ff) |-> state_ff == ST_READ && !pend_wr_ff)
      else $error("busy set without a dispatch");

   a_no_pop_in_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> !cmd_pop)
      else $error("command taken during ring read");

endmodule

// ----- hdl/dual_request_queue_priority_dispatch_top.sv -----
// A plain enqueue, finish or idle tick is retired when the back end takes it; an
// eviction or dispatch does a registered ring RAM read in ST_READ, which blocks new
// commands, then queues its result; a rejection is queued when taken. Rate: 1 item
// per cycle for plain enqueue and finish if the result queue has room.
// Reset is synchronous: pointers, fills and busy flag clear, limits 32, policies evict
// oldest; ring contents are not cleared and no clearing pass runs.
module dual_request_queue_priority_dispatch_top
   import dqpd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic [1:0]            req_kind,
   input  logic [15:0]           req_request_tag,
   input  logic [7:0]            req_slave_address,
   input  logic [1:0]            req_register_kind,
   input  logic [15:0]           req_start_address,
   input  logic [10:0]           req_item_count,
   output logic                  empty,
   input  logic                  pop,
   output logic [1:0]            rsp_event_res,
   output logic [15:0]           rsp_out_tag,
   output logic [7:0]            rsp_out_slave,
   output logic [1:0]            rsp_out_register_kind,
   output logic [15:0]           rsp_out_start,
   output logic [10:0]           rsp_out_count,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   desc_type      req_desc;
   cmd_type       cmd;
   logic          cmd_valid, cmd_pop;
   logic          rsp_full, rsp_push;
   rsp_type       rsp_in, rsp_out;
   csr_write_type csr;

   assign req_desc.tag   = req_request_tag;
   assign req_desc.slave = req_slave_address;
   assign req_desc.rkind = req_register_kind;
   assign req_desc.start = req_start_address;
   assign req_desc.count = req_item_count;

   assign csr_ready = 1'b1;
   assign csr.valid = csr_valid;
   assign csr.index = csr_index;
   assign csr.data  = csr_data;

   dqpd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .kind      (req_kind),
      .desc      (req_desc),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   dqpd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_in)
   );

   dqpd_rspq u_rspq (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_push),
      .wr_data (rsp_in),
      .full    (rsp_full),
      .empty   (empty),
      .rd_data (rsp_out),
      .rd_en   (pop)
   );

   assign rsp_event_res         = rsp_out.ev;
   assign rsp_out_tag           = rsp_out.desc.tag;
   assign rsp_out_slave         = rsp_out.desc.slave;
   assign rsp_out_register_kind = rsp_out.desc.rkind;
   assign rsp_out_start         = rsp_out.desc.start;
   assign rsp_out_count         = rsp_out.desc.count;

endmodule

// ----- test/testbench.sv -----
// Self-checking bench for dual_request_queue_priority_dispatch_top.
// Drives items, register writes and result pops, and predicts every result in a
// class of its own. Depends on dqpd_pkg and the top module only.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import dqpd_pkg::*;

   localparam logic [CSR_IDX_W-1:0]  CSR_UNMAPPED     = 3'd7;
   localparam logic [CSR_DATA_W-1:0] POL_CODE3_HIGH   = 6'h3F;  // policy 3, keep
   localparam logic [CSR_DATA_W-1:0] POL_OLDEST_HIGH  = 6'h3C;  // upper bits ignored
   localparam logic [CSR_DATA_W-1:0] POL_NEWEST_HIGH  = 6'h2D;
   localparam logic [CSR_DATA_W-1:0] LIMIT_ZERO       = 6'd0;
   localparam logic [CSR_DATA_W-1:0] LIMIT_MAX        = 6'h3F;
   localparam int                    MAX_REPORTS      = 10;

   class dispatch_predictor;
      desc_type               ring [2][QUEUE_DEPTH];
      int unsigned            head [2];
      int unsigned            fill [2];
      logic [LIMIT_W-1:0]     limit [2];
      logic [POL_W-1:0]       policy [2];
      bit                     busy;
      rsp_type                pending_events [$];
      int                     failures;
      int                     items_in;
      int                     checked;
      int                     seen [4];

      function new();
         for (int q = 0; q < 2; q++) begin
            head[q]   = 0;
            fill[q]   = 0;
            limit[q]  = LIMIT_RESET;
            policy[q] = POL_EVICT_OLDEST;
         end
         busy = 1'b0;
         failures = 0;
         items_in = 0;
         checked = 0;
         for (int i = 0; i < 4; i++) seen[i] = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_READ_LIMIT:   limit[0]  = data[LIMIT_W-1:0];
            CSR_WRITE_LIMIT:  limit[1]  = data[LIMIT_W-1:0];
            CSR_READ_POLICY:  policy[0] = data[POL_W-1:0];
            CSR_WRITE_POLICY: policy[1] = data[POL_W-1:0];
            default: ;
         endcase
      endfunction

      function void note(event_type ev, desc_type d);
         rsp_type r;
         r.ev   = ev;
         r.desc = d;
         pending_events.insert(pending_events.size(), r);
      endfunction

      function void enqueue(int q, desc_type d);
         int unsigned lim;
         lim = limit[q];
         if (lim == 0) lim = 1;
         if (lim > QUEUE_DEPTH) lim = QUEUE_DEPTH;
         if (fill[q] >= lim) begin
            if (policy[q] == POL_EVICT_OLDEST) begin
               note(EV_EVICT, ring[q][head[q]]);
               head[q] = (head[q] + 1) % QUEUE_DEPTH;
               fill[q]--;
            end else if (policy[q] == POL_EVICT_NEWEST) begin
               fill[q]--;
               note(EV_EVICT, ring[q][(head[q] + fill[q]) % QUEUE_DEPTH]);
            end else if (fill[q] >= QUEUE_DEPTH) begin
               note(EV_REJECT, d);
               return;
            end
         end
         ring[q][(head[q] + fill[q]) % QUEUE_DEPTH] = d;
         fill[q]++;
      endfunction

      function void dispatch(int q, event_type ev);
         note(ev, ring[q][head[q]]);
         head[q] = (head[q] + 1) % QUEUE_DEPTH;
         fill[q]--;
         busy = 1'b1;
      endfunction

      function void accept_item(kind_type k, desc_type d);
         items_in++;
         case (k)
            KIND_ENQ_READ:  enqueue(0, d);
            KIND_ENQ_WRITE: enqueue(1, d);
            KIND_FINISH:    busy = 1'b0;
            default: begin
               if (!busy) begin
                  if (fill[1] > 0) dispatch(1, EV_DISP_WRITE);
                  else if (fill[0] > 0) dispatch(0, EV_DISP_READ);
               end
            end
         endcase
      endfunction

      function void check_event(rsp_type got);
         rsp_type exp;
         if (pending_events.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("ERROR unexpected result: ev=%0d tag=%h slave=%h rk=%0d start=%h count=%0d",
                        got.ev, got.desc.tag, got.desc.slave, got.desc.rkind,
                        got.desc.start, got.desc.count);
            return;
         end
         exp = pending_events[0];
         pending_events.delete(0);
         checked++;
         seen[exp.ev]++;
         if (got.ev !== exp.ev || got.desc.tag !== exp.desc.tag
             || got.desc.slave !== exp.desc.slave || got.desc.rkind !== exp.desc.rkind
             || got.desc.start !== exp.desc.start || got.desc.count !== exp.desc.count) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
               $display("ERROR result %0d mismatch at %0t", checked, $realtime);
               $display("  expected ev=%0d tag=%h slave=%h rk=%0d start=%h count=%0d",
                        exp.ev, exp.desc.tag, exp.desc.slave, exp.desc.rkind,
                        exp.desc.start, exp.desc.count);
               $display("  actual   ev=%0d tag=%h slave=%h rk=%0d start=%h count=%0d",
                        got.ev, got.desc.tag, got.desc.slave, got.desc.rkind,
                        got.desc.start, got.desc.count);
            end
         end
      endfunction

      function int pending();
         return pending_events.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  push;
   logic                  full;
   logic [1:0]            req_kind;
   logic [15:0]           req_request_tag;
   logic [7:0]            req_slave_address;
   logic [1:0]            req_register_kind;
   logic [15:0]           req_start_address;
   logic [10:0]           req_item_count;
   logic                  empty;
   logic                  pop;
   logic [1:0]            rsp_event_res;
   logic [15:0]           rsp_out_tag;
   logic [7:0]            rsp_out_slave;
   logic [1:0]            rsp_out_register_kind;
   logic [15:0]           rsp_out_start;
   logic [10:0]           rsp_out_count;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   dispatch_predictor sb;
   bit                in_idle_on;
   bit                out_stall_on;
   int                stall_left;

   dual_request_queue_priority_dispatch_top u_top (
      .clock                 (clock),
      .reset                 (reset),
      .push                  (push),
      .full                  (full),
      .req_kind              (req_kind),
      .req_request_tag       (req_request_tag),
      .req_slave_address     (req_slave_address),
      .req_register_kind     (req_register_kind),
      .req_start_address     (req_start_address),
      .req_item_count        (req_item_count),
      .empty                 (empty),
      .pop                   (pop),
      .rsp_event_res         (rsp_event_res),
      .rsp_out_tag           (rsp_out_tag),
      .rsp_out_slave         (rsp_out_slave),
      .rsp_out_register_kind (rsp_out_register_kind),
      .rsp_out_start         (rsp_out_start),
      .rsp_out_count         (rsp_out_count),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // both handshakes seen with pre-edge values
   always @(posedge clock) begin
      rsp_type got;
      if (!reset && sb != null) begin
         if (push && !full)
            sb.accept_item(kind_type'(req_kind),
                           {req_request_tag, req_slave_address, req_register_kind,
                            req_start_address, req_item_count});
         if (pop && !empty) begin
            got.ev   = event_type'(rsp_event_res);
            got.desc = {rsp_out_tag, rsp_out_slave, rsp_out_register_kind,
                        rsp_out_start, rsp_out_count};
            sb.check_event(got);
         end
      end
   end

   initial begin
      pop = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            pop = 1'b0;
            stall_left--;
         end else if (out_stall_on && $urandom_range(0, 7) == 0) begin
            pop = 1'b0;
            stall_left = $urandom_range(1, 9) - 1;
         end else begin
            pop = 1'b1;
         end
      end
   end

   initial begin
      #3000000;
      $display("tb: failure");
      $finish;
   end

   function automatic desc_type random_desc();
      desc_type d;
      case ($urandom_range(0, 15))
         0: d = '0;
         1: d = '1;
         default: begin
            d.tag   = 16'($urandom);
            d.slave = 8'($urandom);
            d.rkind = 2'($urandom);
            d.start = 16'($urandom);
            d.count = 11'($urandom_range(0, 2047));
         end
      endcase
      return d;
   endfunction

   task automatic send_item(kind_type k, desc_type d);
      if (in_idle_on && $urandom_range(0, 5) == 0) begin
         push = 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      push              = 1'b1;
      req_kind          = k;
      req_request_tag   = d.tag;
      req_slave_address = d.slave;
      req_register_kind = d.rkind;
      req_start_address = d.start;
      req_item_count    = d.count;
      @(posedge clock);
      while (full !== 1'b0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      sb.write_reg(idx, data);
      @(negedge clock);
   endtask

   task automatic set_config(logic [CSR_DATA_W-1:0] rl, logic [CSR_DATA_W-1:0] wl,
                             logic [CSR_DATA_W-1:0] rp, logic [CSR_DATA_W-1:0] wp);
      write_reg(CSR_READ_LIMIT, rl);
      write_reg(CSR_WRITE_LIMIT, wl);
      write_reg(CSR_READ_POLICY, rp);
      write_reg(CSR_WRITE_POLICY, wp);
      csr_valid = 1'b0;
   endtask

   // items that yield nothing may still be in flight once the queue is empty
   task automatic drain(int extra);
      push = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   // mostly tick/finish pairs around enqueues, with some out-of-order noise
   task automatic run_items(int n, int enq_pct);
      kind_type k;
      bit       after_tick;
      after_tick = 1'b0;
      repeat (n) begin
         if ($urandom_range(0, 99) < enq_pct) begin
            k = $urandom_range(0, 1) ? KIND_ENQ_WRITE : KIND_ENQ_READ;
         end else begin
            if ($urandom_range(0, 99) < 85) k = after_tick ? KIND_FINISH : KIND_TICK;
            else k = after_tick ? KIND_TICK : KIND_FINISH;
            after_tick = (k == KIND_TICK);
         end
         send_item(k, random_desc());
      end
   endtask

   task automatic run_phase(logic [CSR_DATA_W-1:0] rl, logic [CSR_DATA_W-1:0] wl,
                            logic [CSR_DATA_W-1:0] rp, logic [CSR_DATA_W-1:0] wp,
                            int n, int enq_pct);
      set_config(rl, wl, rp, wp);
      run_items(n, enq_pct);
      drain(4);
   endtask

   initial begin
      reset             = 1'b1;
      push              = 1'b0;
      req_kind          = KIND_TICK;
      req_request_tag   = '0;
      req_slave_address = '0;
      req_register_kind = '0;
      req_start_address = '0;
      req_item_count    = '0;
      csr_valid         = 1'b0;
      csr_index         = CSR_READ_LIMIT;
      csr_data          = '0;
      in_idle_on        = 1'b1;
      out_stall_on      = 1'b1;
      sb = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: empty tick, stray finish, priority and busy handling
      send_item(KIND_TICK, random_desc());
      send_item(KIND_FINISH, random_desc());
      send_item(KIND_ENQ_READ, '1);
      send_item(KIND_ENQ_READ, '0);
      send_item(KIND_ENQ_WRITE, random_desc());
      send_item(KIND_TICK, '0);
      send_item(KIND_TICK, '1);
      send_item(KIND_ENQ_WRITE, '1);
      send_item(KIND_FINISH, '0);
      send_item(KIND_TICK, '0);
      send_item(KIND_FINISH, '1);
      send_item(KIND_TICK, random_desc());
      send_item(KIND_FINISH, random_desc());
      send_item(KIND_TICK, random_desc());
      send_item(KIND_FINISH, random_desc());
      send_item(KIND_TICK, random_desc());
      drain(4);

      // evict oldest on reads, limit zero with evict newest on writes
      set_config(6'd2, LIMIT_ZERO, 6'(POL_EVICT_OLDEST), 6'(POL_EVICT_NEWEST));
      send_item(KIND_ENQ_READ, random_desc());
      send_item(KIND_ENQ_READ, random_desc());
      send_item(KIND_ENQ_READ, random_desc());
      send_item(KIND_ENQ_WRITE, random_desc());
      send_item(KIND_ENQ_WRITE, random_desc());
      drain(4);

      run_phase(LIMIT_ZERO, LIMIT_MAX, 6'(POL_EVICT_NEWEST), 6'(POL_KEEP), 110, 75);
      write_reg(CSR_UNMAPPED, 6'h2A);
      run_phase(6'd32, 6'd32, 6'(POL_KEEP), POL_CODE3_HIGH, 120, 80);
      run_phase(6'd3, 6'd5, 6'(POL_EVICT_OLDEST), 6'(POL_EVICT_NEWEST), 120, 50);
      run_phase(6'd1, 6'd1, POL_OLDEST_HIGH, 6'(POL_EVICT_OLDEST), 100, 50);
      run_phase(6'd17, 6'd40, 6'(POL_KEEP), POL_NEWEST_HIGH, 120, 35);
      in_idle_on   = 1'b0;
      out_stall_on = 1'b0;
      run_phase(6'd32, 6'd32, 6'(POL_EVICT_OLDEST), 6'(POL_EVICT_OLDEST), 140, 55);
      drain(10);

      $display("summary: %0d items accepted, %0d results checked over 8 settings",
               sb.items_in, sb.checked);
      $display("summary: %0d read and %0d write dispatches, %0d evictions, %0d rejections",
               sb.seen[EV_DISP_READ], sb.seen[EV_DISP_WRITE], sb.seen[EV_EVICT],
               sb.seen[EV_REJECT]);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- dual_request_queue_priority_dispatch_top.f -----
hdl/dqpd_pkg.sv
hdl/dqpd_ram.sv
hdl/dqpd_front.sv
hdl/dqpd_rspq.sv
hdl/dqpd_back.sv
hdl/dual_request_queue_priority_dispatch_top.sv
test/testbench.sv
